FILE: sv/artt_pkg.sv
// shared types and constants for the address region tag table
// no dependencies
package artt_pkg;

	localparam int REGION_COUNT = 64;
	localparam int TAG_BITS     = 8;
	localparam int IDX_W        = $clog2(REGION_COUNT);
	localparam int CNT_W        = $clog2(REGION_COUNT + 1);

	// item modes
	localparam logic [1:0] MODE_READ  = 2'd0;
	localparam logic [1:0] MODE_WRITE = 2'd1;
	localparam logic [1:0] MODE_ALLOC = 2'd2;
	localparam logic [1:0] MODE_FREE  = 2'd3;

	// result status codes
	localparam logic [1:0] ST_DONE      = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_IGNORED   = 2'd2;
	localparam logic [1:0] ST_NOT_FOUND = 2'd3;

	typedef logic [TAG_BITS-1:0] tag_t;
	typedef logic [IDX_W-1:0]    idx_t;

	// one stored region
	typedef struct packed {
		logic [63:0] start;
		logic [63:0] length;
		tag_t        tag;
	} entry_t;

	// registered read result of the region store
	typedef struct packed {
		logic   valid;
		entry_t entry;
	} rd_t;

	// write command to the region store
	typedef struct packed {
		logic   write;
		logic   clear;
		idx_t   idx;
		entry_t entry;
	} wr_t;

	// input tag to stored tag width
	function automatic tag_t tag_from_in(input logic [7:0] t);
		logic [15:0] w;
		w = 16'(t);
		return w[TAG_BITS-1:0];
	endfunction

	// stored tag to output tag width
	function automatic logic [7:0] tag_to_out(input tag_t t);
		logic [15:0] w;
		w = 16'(t);
		return w[7:0];
	endfunction

endpackage

FILE: sv/artt_store.sv
// region store: entry memory with one write and one registered read port,
// plus per-entry valid flops cleared by reset; depends on artt_pkg
module artt_store (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           rd_en,
	input  artt_pkg::idx_t rd_idx,
	input  artt_pkg::wr_t  wr,
	output artt_pkg::rd_t  rd
);
	import artt_pkg::*;

	entry_t                  mem_q [REGION_COUNT];
	logic [REGION_COUNT-1:0] valid_q;
	logic                    rd_valid_q;
	entry_t                  rd_entry_q;

	// entry memory, no reset
	always_ff @(posedge clk) begin
		if (wr.write) begin
			mem_q[wr.idx] <= wr.entry;
		end
		if (rd_en) begin
			rd_entry_q <= mem_q[rd_idx];
		end
	end

	// valid bits and registered valid read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr.write) begin
				valid_q[wr.idx] <= 1'b1;
			end else if (wr.clear) begin
				valid_q[wr.idx] <= 1'b0;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_idx];
			end
		end
	end

	assign rd.valid = rd_valid_q;
	assign rd.entry = rd_entry_q;

endmodule

FILE: sv/address_region_tag_table.sv
// top level of the address region tag table: sequencer sweeping the region
// store through one compare unit; depends on artt_pkg and artt_store
//
//  channel | transfer when         | fields
//  --------+-----------------------+-------------------------------------
//  req     | req_valid & !req_stall| mode, address, region_size, tag_in
//  rsp     | rsp_valid & !rsp_stall| hit, tag_out, status
//
// an item is taken in the idle step, then every entry is swept through the
// single store read port and the last read is checked, then the item is
// resolved; an ignored allocate or free skips the sweep and goes to resolve.
// req_stall is high while an item is in work; a stalled result waits in the
// output register and holds the sequencer in its last step.
// reset clears all valid bits at once, no clearing pass is needed.
module address_region_tag_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  mode,
	input  logic [63:0] address,
	input  logic [63:0] region_size,
	input  logic [7:0]  tag_in,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic        hit,
	output logic [7:0]  tag_out,
	output logic [1:0]  status
);
	import artt_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_EVAL
	} state_t;

	state_t       state_q;
	logic [1:0]   mode_q;
	logic [63:0]  addr_q;
	logic [63:0]  size_q;
	tag_t         tag_q;
	logic         ign_q;
	logic [CNT_W-1:0] iss_q;
	logic         rv_q;
	idx_t         rix_q;
	logic         best_q;
	logic [63:0]  best_start_q;
	logic [63:0]  best_len_q;
	tag_t         best_tag_q;
	logic         match_q;
	idx_t         match_idx_q;
	logic         free_q;
	idx_t         free_idx_q;
	logic         rsp_valid_q;
	logic         hit_q;
	logic [7:0]   tag_out_q;
	logic [1:0]   status_q;

	logic  is_access;
	logic  issuing;
	logic  take_best;
	logic  exact;
	logic  acc_hit;
	logic  go;
	logic  slot_ok;
	idx_t  slot;
	rd_t   rd;
	wr_t   wr;

	artt_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (issuing),
		.rd_idx (iss_q[IDX_W-1:0]),
		.wr     (wr),
		.rd     (rd)
	);

	// shared compare unit on the entry coming out of the store
	always_comb begin
		is_access = (mode_q == MODE_READ) || (mode_q == MODE_WRITE);
		issuing   = (state_q == S_SCAN) && (iss_q < CNT_W'(REGION_COUNT));
		take_best = rd.valid && (rd.entry.start <= addr_q) &&
			(!best_q || (rd.entry.start > best_start_q));
		exact     = rd.valid && (rd.entry.start == addr_q);
		acc_hit   = best_q && ((addr_q - best_start_q) < best_len_q);
	end

	// resolve step: slot choice and store update
	always_comb begin
		go      = (state_q == S_EVAL) && (!rsp_valid_q || !rsp_stall);
		slot_ok = match_q || free_q;
		slot    = match_q ? match_idx_q : free_idx_q;
		wr.write       = go && !ign_q && (mode_q == MODE_ALLOC) && slot_ok;
		wr.clear       = go && !ign_q && (mode_q == MODE_FREE) && match_q;
		wr.idx         = (mode_q == MODE_FREE) ? match_idx_q : slot;
		wr.entry.start  = addr_q;
		wr.entry.length = size_q;
		wr.entry.tag    = tag_q;
	end

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			mode_q       <= MODE_READ;
			addr_q       <= '0;
			size_q       <= '0;
			tag_q        <= '0;
			ign_q        <= 1'b0;
			iss_q        <= '0;
			rv_q         <= 1'b0;
			rix_q        <= '0;
			best_q       <= 1'b0;
			best_start_q <= '0;
			best_len_q   <= '0;
			best_tag_q   <= '0;
			match_q      <= 1'b0;
			match_idx_q  <= '0;
			free_q       <= 1'b0;
			free_idx_q   <= '0;
			rsp_valid_q  <= 1'b0;
			hit_q        <= 1'b0;
			tag_out_q    <= '0;
			status_q     <= ST_DONE;
		end else begin
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						mode_q  <= mode;
						addr_q  <= address;
						size_q  <= region_size;
						tag_q   <= tag_from_in(tag_in);
						ign_q   <= ((mode == MODE_ALLOC) &&
							((address == 64'd0) || (region_size == 64'd0))) ||
							((mode == MODE_FREE) && (address == 64'd0));
						iss_q   <= '0;
						rv_q    <= 1'b0;
						best_q  <= 1'b0;
						match_q <= 1'b0;
						free_q  <= 1'b0;
						if (((mode == MODE_ALLOC) &&
							((address == 64'd0) || (region_size == 64'd0))) ||
							((mode == MODE_FREE) && (address == 64'd0))) begin
							state_q <= S_EVAL;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					// issue side
					rv_q  <= issuing;
					rix_q <= iss_q[IDX_W-1:0];
					if (issuing) begin
						iss_q <= iss_q + CNT_W'(1);
					end
					// check side
					if (rv_q) begin
						if (is_access) begin
							if (take_best) begin
								best_q       <= 1'b1;
								best_start_q <= rd.entry.start;
								best_len_q   <= rd.entry.length;
								best_tag_q   <= rd.entry.tag;
							end
						end else begin
							if (exact && !match_q) begin
								match_q     <= 1'b1;
								match_idx_q <= rix_q;
							end
							if (!rd.valid && !free_q) begin
								free_q     <= 1'b1;
								free_idx_q <= rix_q;
							end
						end
					end
					if (!issuing && !rv_q) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					if (go) begin
						rsp_valid_q <= 1'b1;
						hit_q       <= 1'b0;
						tag_out_q   <= '0;
						status_q    <= ST_DONE;
						if (is_access) begin
							hit_q <= acc_hit;
							if (acc_hit) begin
								tag_out_q <= tag_to_out(best_tag_q);
							end
						end else if (ign_q) begin
							status_q <= ST_IGNORED;
						end else if (mode_q == MODE_ALLOC) begin
							if (!slot_ok) begin
								status_q <= ST_FULL;
							end
						end else if (!match_q) begin
							status_q <= ST_NOT_FOUND;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign hit       = hit_q;
	assign tag_out   = tag_out_q;
	assign status    = status_q;

endmodule
